/* rtl/core/buffer_pool_page_replacement_core_defines.svh */
// Assertion macros for the buffer pool core.
`ifndef BUFFER_POOL_PAGE_REPLACEMENT_CORE_DEFINES_SVH
`define BUFFER_POOL_PAGE_REPLACEMENT_CORE_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define BPR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define BPR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/bpr_pkg.sv */
// ----------------------------------------------------------------------------
// Buffer pool package
// Shared types and codes for the buffer pool page replacement core.
// ----------------------------------------------------------------------------
`default_nettype none
package bpr_pkg;

  localparam logic       CMD_PIN   = 1'b0;
  localparam logic       CMD_UNPIN = 1'b1;

  localparam logic [1:0] POL_LRU   = 2'd0;
  localparam logic [1:0] POL_MRU   = 2'd1;
  localparam logic [1:0] POL_CLOCK = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_MISS   = 2'd2;

  // Command as queued between front and back.
  typedef struct packed {
    logic        command;
    logic [15:0] page_number;
    logic        mark_dirty;
  } cmd_t;

  // Result of one command.
  typedef struct packed {
    logic [1:0]  status;
    logic        was_hit;
    logic [2:0]  frame_index;
    logic [7:0]  pins_now;
    logic        writeback_valid;
    logic [15:0] writeback_page;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_SCAN,
    S_CLOCK,
    S_APPLY,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

/* rtl/core/bpr_front.sv */
// ----------------------------------------------------------------------------
// Buffer pool front end
// Accepts commands, unpacks them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none
module bpr_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [17:0]   in_data,
  output logic               q_valid,
  input  wire logic          q_ready,
  output bpr_pkg::cmd_t      q_cmd
);

  bpr_pkg::cmd_t mem [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    count;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = mem[rptr];

  // Queue pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (in_valid && in_ready) wptr <= ~wptr;
      if (q_valid && q_ready) rptr <= ~rptr;
      count <= count + {1'b0, in_valid && in_ready} - {1'b0, q_valid && q_ready};
    end
  end

  // Store the unpacked command.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mem[wptr].command     <= in_data[0];
      mem[wptr].page_number <= in_data[16:1];
      mem[wptr].mark_dirty  <= in_data[17];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/bpr_back.sv */
// ----------------------------------------------------------------------------
// Buffer pool back end
// Looks up pages, scans for victims and updates the frame table.
// ----------------------------------------------------------------------------
`default_nettype none
module bpr_back #(
  parameter int NUM_FRAMES = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [1:0]    policy,
  input  wire logic          q_valid,
  output logic               q_ready,
  input  wire bpr_pkg::cmd_t q_cmd,
  output logic               res_valid,
  input  wire logic          res_ready,
  output bpr_pkg::res_t      res
);

  localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

  // Frame table.
  logic [NUM_FRAMES-1:0] fvalid;
  logic [NUM_FRAMES-1:0] fdirty;
  logic [NUM_FRAMES-1:0] fref;
  logic [15:0]           fpage  [NUM_FRAMES];
  logic [7:0]            fpins  [NUM_FRAMES];
  logic [31:0]           fstamp [NUM_FRAMES];
  logic [IW-1:0]         hand;
  logic [31:0]           useq;

  bpr_pkg::state_t state, state_next;
  bpr_pkg::cmd_t   cur;
  logic [IW-1:0]   idx;
  logic [IW+1:0]   steps;
  logic            found;
  logic [IW-1:0]   fidx;
  logic            have_empty;
  logic [IW-1:0]   empty_idx;
  logic            have_best;
  logic [IW-1:0]   best;
  logic [31:0]     best_stamp;
  logic            clk_any;

  logic [IW-1:0]   idx_inc;
  logic            idx_last;
  logic            cand;
  logic [IW-1:0]   tgt;
  logic [7:0]      pins_dec;
  logic [7:0]      pins_inc;
  logic [31:0]     stamp_next;
  bpr_pkg::res_t   res_apply;

  assign idx_last   = (idx == IW'(NUM_FRAMES - 1));
  assign idx_inc    = idx_last ? '0 : idx + 1'b1;
  assign cand       = fvalid[idx] && (fpins[idx] == 8'd0);
  assign tgt        = have_empty ? empty_idx : best;
  assign pins_dec   = (fpins[fidx] != 8'd0) ? fpins[fidx] - 8'd1 : 8'd0;
  assign pins_inc   = (fpins[fidx] != 8'd255) ? fpins[fidx] + 8'd1 : 8'd255;
  assign stamp_next = (useq != '1) ? useq + 32'd1 : useq;

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      bpr_pkg::S_IDLE:   if (q_valid) state_next = bpr_pkg::S_LOOKUP;
      bpr_pkg::S_LOOKUP: if (idx_last) begin
        if (found || (fvalid[idx] && fpage[idx] == cur.page_number) ||
            cur.command == bpr_pkg::CMD_UNPIN)
          state_next = bpr_pkg::S_APPLY;
        else if (have_empty || !fvalid[idx])
          state_next = bpr_pkg::S_APPLY;
        else if (policy == bpr_pkg::POL_CLOCK)
          state_next = bpr_pkg::S_CLOCK;
        else
          state_next = bpr_pkg::S_SCAN;
      end
      bpr_pkg::S_SCAN:   if (idx_last) state_next = bpr_pkg::S_APPLY;
      bpr_pkg::S_CLOCK:
        if (!clk_any || (cand && !fref[idx]) || steps == (IW+2)'(2 * NUM_FRAMES))
          state_next = bpr_pkg::S_APPLY;
      bpr_pkg::S_APPLY:  state_next = bpr_pkg::S_OUT;
      bpr_pkg::S_OUT:    if (res_ready) state_next = bpr_pkg::S_IDLE;
      default:           state_next = bpr_pkg::S_IDLE;
    endcase
  end

  // Output logic.
  always_comb begin
    q_ready   = 1'b0;
    res_valid = 1'b0;
    unique case (state)
      bpr_pkg::S_IDLE: q_ready   = 1'b1;
      bpr_pkg::S_OUT:  res_valid = 1'b1;
      default: ;
    endcase
  end

  // Result of the command once the lookup and the victim search are done.
  always_comb begin
    res_apply = '0;
    if (found) begin
      res_apply.was_hit     = 1'b1;
      res_apply.frame_index = 3'(fidx);
      res_apply.pins_now    = (cur.command == bpr_pkg::CMD_UNPIN) ? pins_dec : pins_inc;
    end else if (cur.command == bpr_pkg::CMD_UNPIN) begin
      res_apply.status = bpr_pkg::ST_MISS;
    end else if (have_empty || have_best) begin
      res_apply.frame_index = 3'(tgt);
      res_apply.pins_now    = 8'd1;
      if (!have_empty && fdirty[best]) begin
        res_apply.writeback_valid = 1'b1;
        res_apply.writeback_page  = fpage[best];
      end
    end else begin
      res_apply.status = bpr_pkg::ST_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= bpr_pkg::S_IDLE;
    else     state <= state_next;
  end

  // Datapath: one frame visited per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= '0;
      fdirty <= '0;
      fref   <= '0;
      hand   <= '0;
      useq   <= '0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        fpins[i]  <= 8'd0;
        fstamp[i] <= 32'd0;
      end
    end else begin
      unique case (state)
        bpr_pkg::S_IDLE: begin
          cur        <= q_cmd;
          idx        <= '0;
          found      <= 1'b0;
          have_empty <= 1'b0;
          have_best  <= 1'b0;
          clk_any    <= 1'b0;
          steps      <= '0;
        end
        bpr_pkg::S_LOOKUP: begin
          if (!found && fvalid[idx] && fpage[idx] == cur.page_number) begin
            found <= 1'b1;
            fidx  <= idx;
          end
          if (!have_empty && !fvalid[idx]) begin
            have_empty <= 1'b1;
            empty_idx  <= idx;
          end
          // Remember whether any frame could be evicted at all.
          if (cand) clk_any <= 1'b1;
          // The clock sweep starts at the hand, the stamp scan at frame 0.
          idx <= (idx_last && policy == bpr_pkg::POL_CLOCK) ? hand : idx_inc;
        end
        bpr_pkg::S_SCAN: begin
          if (cand && (!have_best ||
              (policy == bpr_pkg::POL_MRU ? fstamp[idx] > best_stamp
                                          : fstamp[idx] < best_stamp))) begin
            have_best  <= 1'b1;
            best       <= idx;
            best_stamp <= fstamp[idx];
          end
          idx <= idx_inc;
        end
        bpr_pkg::S_CLOCK: begin
          steps <= steps + 1'b1;
          if (!clk_any) begin
            hand <= '0;
          end else begin
            if (cand) begin
              if (fref[idx]) fref[idx] <= 1'b0;
              else begin
                have_best <= 1'b1;
                best      <= idx;
              end
            end
            hand <= idx_inc;
            idx  <= idx_inc;
          end
        end
        bpr_pkg::S_APPLY: begin
          res <= res_apply;
          if (found) begin
            if (cur.command == bpr_pkg::CMD_UNPIN) begin
              fdirty[fidx] <= cur.mark_dirty;
              fpins[fidx]  <= pins_dec;
            end else begin
              fpins[fidx]  <= pins_inc;
              fref[fidx]   <= 1'b1;
              fstamp[fidx] <= stamp_next;
              useq         <= stamp_next;
            end
          end else if (cur.command != bpr_pkg::CMD_UNPIN && (have_empty || have_best)) begin
            fvalid[tgt] <= 1'b1;
            fpage[tgt]  <= cur.page_number;
            fpins[tgt]  <= 8'd1;
            fdirty[tgt] <= 1'b0;
            fref[tgt]   <= 1'b1;
            fstamp[tgt] <= stamp_next;
            useq        <= stamp_next;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/core/buffer_pool_page_replacement_core.sv */
// Each command looks at every frame; after a hit, an empty frame or an unpin it goes on,
// else LRU/MRU rescans all frames or clock sweeps from the hand; one frame per cycle.
// Throughput: one command at a time through the back end; a two-entry queue in
// front takes new commands meanwhile.
// Reset (synchronous, rst high) empties all frames and sets policy to LRU.
// ----------------------------------------------------------------------------
// Buffer pool page replacement core
// Frame table with LRU, MRU and clock victim selection on stream ports.
// ----------------------------------------------------------------------------
`default_nettype none
`include "buffer_pool_page_replacement_core_defines.svh"
module buffer_pool_page_replacement_core #(
  parameter int NUM_FRAMES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // command[0], page_number[16:1], mark_dirty[17], zero fill
  input  wire logic [23:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[1:0], was_hit[2], frame_index[5:3], pins_now[13:6],
  // writeback_valid[14], writeback_page[30:15], zero fill
  output logic [31:0]      m_axis_tdata
);

  logic          q_valid;
  logic          q_ready;
  bpr_pkg::cmd_t q_cmd;
  bpr_pkg::res_t res;
  logic [1:0]    policy;

  assign cfg_ready = 1'b1;

  // Policy register.
  always_ff @(posedge clk) begin
    if (rst) policy <= bpr_pkg::POL_LRU;
    else if (cfg_valid) policy <= cfg_data;
  end

  bpr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata[17:0]),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd)
  );

  bpr_back #(.NUM_FRAMES(NUM_FRAMES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .policy    (policy),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_cmd     (q_cmd),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = {1'b0, res.writeback_page, res.writeback_valid, res.pins_now,
                         res.frame_index, res.was_hit, res.status};

  `BPR_ASSERT_IMP(a_miss_no_hit, m_axis_tvalid && res.status != bpr_pkg::ST_DONE,
    !res.was_hit && !res.writeback_valid, "failed command reports a hit")
  `BPR_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  `BPR_ASSERT_IMP(a_wb_miss, m_axis_tvalid && res.writeback_valid,
    !res.was_hit && res.pins_now == 8'd1, "writeback on a hit")

endmodule
`default_nettype wire

/* dv/buffer_pool_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buffer pool result checker
// Watches the config, command and result channels, keeps its own frame table
// and compares every result transaction field by field with the prediction.
// ----------------------------------------------------------------------------
module buffer_pool_checker #(
  parameter int NUM_FRAMES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  output int          errors,
  output int          pending,
  output int          results_seen,
  output int          evictions_seen
);

  logic [1:0]    policy;
  logic          fr_valid [NUM_FRAMES];
  logic [15:0]   fr_page  [NUM_FRAMES];
  logic [7:0]    fr_pins  [NUM_FRAMES];
  logic          fr_dirty [NUM_FRAMES];
  logic          fr_ref   [NUM_FRAMES];
  logic [31:0]   fr_stamp [NUM_FRAMES];
  int            hand;
  logic [31:0]   use_seq;
  bpr_pkg::res_t expected_results[$];

  function automatic logic [31:0] bump_stamp();
    if (use_seq != 32'hFFFF_FFFF) use_seq = use_seq + 32'd1;
    return use_seq;
  endfunction

  // Victim search under CLOCK: referenced unpinned frames get a second chance.
  function automatic int clock_victim();
    int h;
    bit any;
    any = 0;
    for (int i = 0; i < NUM_FRAMES; i++) if (fr_valid[i] && fr_pins[i] == 8'd0) any = 1;
    if (!any) begin
      hand = 0;
      return -1;
    end
    for (int s = 0; s <= 2 * NUM_FRAMES; s++) begin
      h = hand % NUM_FRAMES;
      hand = (h + 1) % NUM_FRAMES;
      if (fr_valid[h] && fr_pins[h] == 8'd0) begin
        if (fr_ref[h]) fr_ref[h] = 1'b0;
        else return h;
      end
    end
    return -1;
  endfunction

  // Victim search under LRU or MRU: extreme stamp, lowest index on ties.
  function automatic int stamp_victim(bit most_recent);
    int best;
    best = -1;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (!(fr_valid[i] && fr_pins[i] == 8'd0)) continue;
      if (best < 0 || (most_recent ? fr_stamp[i] > fr_stamp[best]
                                   : fr_stamp[i] < fr_stamp[best]))
        best = i;
    end
    return best;
  endfunction

  // Applies one command to the frame table and returns its result.
  function automatic bpr_pkg::res_t apply_command(bpr_pkg::cmd_t c);
    bpr_pkg::res_t r;
    int f;
    r = '0;
    f = -1;
    for (int i = 0; i < NUM_FRAMES; i++)
      if (f < 0 && fr_valid[i] && fr_page[i] == c.page_number) f = i;
    if (c.command == bpr_pkg::CMD_UNPIN) begin
      if (f < 0) begin
        r.status = bpr_pkg::ST_MISS;
      end else begin
        if (fr_pins[f] != 8'd0) fr_pins[f] = fr_pins[f] - 8'd1;
        fr_dirty[f] = c.mark_dirty;
        r.was_hit = 1'b1;
        r.frame_index = f[2:0];
        r.pins_now = fr_pins[f];
      end
    end else if (f >= 0) begin
      if (fr_pins[f] != 8'hFF) fr_pins[f] = fr_pins[f] + 8'd1;
      fr_stamp[f] = bump_stamp();
      fr_ref[f] = 1'b1;
      r.was_hit = 1'b1;
      r.frame_index = f[2:0];
      r.pins_now = fr_pins[f];
    end else begin
      for (int i = 0; i < NUM_FRAMES; i++) if (f < 0 && !fr_valid[i]) f = i;
      if (f < 0) begin
        f = (policy == bpr_pkg::POL_CLOCK) ? clock_victim()
                                           : stamp_victim(policy == bpr_pkg::POL_MRU);
        if (f >= 0 && fr_dirty[f]) begin
          r.writeback_valid = 1'b1;
          r.writeback_page = fr_page[f];
        end
      end
      if (f < 0) begin
        r.status = bpr_pkg::ST_FULL;
      end else begin
        fr_valid[f] = 1'b1;
        fr_page[f] = c.page_number;
        fr_pins[f] = 8'd1;
        fr_dirty[f] = 1'b0;
        fr_ref[f] = 1'b1;
        fr_stamp[f] = bump_stamp();
        r.frame_index = f[2:0];
        r.pins_now = 8'd1;
      end
    end
    return r;
  endfunction

  // Predicts on accepted commands and compares accepted results.
  always @(posedge clk) begin
    bpr_pkg::res_t got, exp_r;
    bpr_pkg::cmd_t c;
    if (rst) begin
      policy = bpr_pkg::POL_LRU;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        fr_valid[i] = 1'b0; fr_page[i] = 16'd0; fr_pins[i] = 8'd0;
        fr_dirty[i] = 1'b0; fr_ref[i] = 1'b0; fr_stamp[i] = 32'd0;
      end
      hand = 0;
      use_seq = 32'd0;
    end else begin
      if (cfg_valid && cfg_ready) policy = cfg_data;
      if (m_axis_tvalid && m_axis_tready) begin
        got.status          = m_axis_tdata[1:0];
        got.was_hit         = m_axis_tdata[2];
        got.frame_index     = m_axis_tdata[5:3];
        got.pins_now        = m_axis_tdata[13:6];
        got.writeback_valid = m_axis_tdata[14];
        got.writeback_page  = m_axis_tdata[30:15];
        results_seen++;
        if (got.writeback_valid) evictions_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.status != exp_r.status || got.was_hit != exp_r.was_hit ||
              got.frame_index != exp_r.frame_index || got.pins_now != exp_r.pins_now ||
              got.writeback_valid != exp_r.writeback_valid ||
              got.writeback_page != exp_r.writeback_page) begin
            $display("%0t: mismatch expected st=%0d hit=%0d fr=%0d pins=%0d wb=%0d/%h",
                     $time, exp_r.status, exp_r.was_hit, exp_r.frame_index,
                     exp_r.pins_now, exp_r.writeback_valid, exp_r.writeback_page);
            $display("%0t:          actual   st=%0d hit=%0d fr=%0d pins=%0d wb=%0d/%h",
                     $time, got.status, got.was_hit, got.frame_index,
                     got.pins_now, got.writeback_valid, got.writeback_page);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        c.command = s_axis_tdata[0];
        c.page_number = s_axis_tdata[16:1];
        c.mark_dirty = s_axis_tdata[17];
        expected_results.insert(expected_results.size(), apply_command(c));
      end
    end
    pending = expected_results.size();
  end

  initial begin
    errors = 0;
    pending = 0;
    results_seen = 0;
    evictions_seen = 0;
  end
endmodule

/* dv/tb_buffer_pool_page_replacement_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buffer pool core testbench
// Drives pin and unpin commands under every replacement policy with varying
// stream back-pressure; a separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_buffer_pool_page_replacement_core;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  int          errors, pending, results_seen, evictions_seen;
  int          send_idle_pct, recv_stall_pct;
  int          quiet_cycles;
  int          commands_sent;
  logic [15:0] page_base;

  buffer_pool_page_replacement_core DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  buffer_pool_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .errors(errors), .pending(pending), .results_seen(results_seen),
    .evictions_seen(evictions_seen)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Random receiver stalls, changed on the falling edge.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles with no transaction on any channel.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Sends one command transaction, with a random gap before it.
  task automatic send_command(logic cmd, logic [15:0] page, logic dirty);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {6'd0, dirty, page, cmd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    commands_sent++;
  endtask

  // Waits for all results, lets the core settle, then writes the policy.
  task automatic set_policy(logic [1:0] pol);
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = pol;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Pin/unpin pairs and single commands, mostly on a small page set so eviction happens often.
  task automatic random_commands(int count);
    logic [15:0] page;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: page = 16'($urandom);
        1, 2, 3, 4, 5: page = page_base + 16'($urandom_range(11));
        default: page = page_base + 16'($urandom_range(5));
      endcase
      if ($urandom_range(2) == 0) begin
        send_command(bpr_pkg::CMD_PIN, page, 1'($urandom_range(1)));
        send_command(bpr_pkg::CMD_UNPIN, page, 1'($urandom_range(1)));
      end else begin
        send_command($urandom_range(1) ? bpr_pkg::CMD_UNPIN : bpr_pkg::CMD_PIN, page,
                     1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    rst = 1;
    cfg_valid = 0;
    cfg_data = bpr_pkg::POL_LRU;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    m_axis_tready = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    commands_sent = 0;
    page_base = 16'h0100;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: unpin miss, fill with extreme pages, all pinned, saturation.
    send_command(bpr_pkg::CMD_UNPIN, 16'hFFFF, 1'b1);
    send_command(bpr_pkg::CMD_PIN, 16'h0000, 1'b0);
    send_command(bpr_pkg::CMD_PIN, 16'hFFFF, 1'b0);
    for (int i = 0; i < 6; i++) send_command(bpr_pkg::CMD_PIN, 16'(16'h5555 + i), 1'b0);
    send_command(bpr_pkg::CMD_PIN, 16'hAAAA, 1'b0);
    send_command(bpr_pkg::CMD_UNPIN, 16'h0000, 1'b1);
    send_command(bpr_pkg::CMD_UNPIN, 16'h0000, 1'b1);
    send_command(bpr_pkg::CMD_UNPIN, 16'hFFFF, 1'b1);
    send_command(bpr_pkg::CMD_PIN, 16'hAAAA, 1'b1);
    send_command(bpr_pkg::CMD_PIN, 16'h1234, 1'b0);
    set_policy(bpr_pkg::POL_MRU);
    send_command(bpr_pkg::CMD_UNPIN, 16'h5555, 1'b1);
    send_command(bpr_pkg::CMD_UNPIN, 16'h5556, 1'b0);
    send_command(bpr_pkg::CMD_PIN, 16'h7777, 1'b0);
    send_command(bpr_pkg::CMD_PIN, 16'h8888, 1'b0);
    for (int i = 0; i < 256; i++) send_command(bpr_pkg::CMD_PIN, 16'h5557, 1'b0);

    // Random phases across policies, including the unused code and idling mixes.
    for (int ph = 0; ph < 8; ph++) begin
      set_policy(ph == 7 ? 2'd3 : 2'(ph % 3));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      page_base = 16'($urandom);
      random_commands(40);
    end
    set_policy(bpr_pkg::POL_CLOCK);

    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    $display("Sent %0d commands under LRU, MRU, clock and the unused policy code;", commands_sent);
    $display("checked %0d results, %0d of them with a dirty writeback.", results_seen,
             evictions_seen);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
